>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every enabled edge
`define AST_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Request and status codes and data types of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 2;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [REQ_W-1:0]         t_req;
    typedef logic [ST_W-1:0]          t_status;

    // request codes
    localparam t_req REQ_PUSH_BACK  = 3'd0;
    localparam t_req REQ_PUSH_FRONT = 3'd1;
    localparam t_req REQ_POP_BACK   = 3'd2;
    localparam t_req REQ_POP_FRONT  = 3'd3;
    localparam t_req REQ_QUERY      = 3'd4;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // front and back read value of an empty queue
    localparam t_data EMPTY_READ = -32'sd1;

endpackage

>>> src/deq_if.sv
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for queue requests and their responses
// ----------------------------------------------------------------------------
interface deq_req_if
    import deq_pkg::*;
();
    logic  valid;
    logic  ready;
    t_req  req_type;
    t_data push_value;

    modport source (output valid, req_type, push_value, input ready);
    modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface deq_rsp_if
    import deq_pkg::*;
#(
    parameter int CNT_W = 7
) ();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [CNT_W-1:0] element_count;
    t_data            front_value;
    t_data            back_value;

    modport source (output valid, status, element_count, front_value, back_value,
                    input ready);
    modport sink   (input valid, status, element_count, front_value, back_value,
                    output ready);
endinterface

>>> src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Ring storage: one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

>>> src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a ring memory
// ----------------------------------------------------------------------------
// Each request (push back, push front, pop back, pop front, query) returns one
// response with status, element count and the front and back values after the
// request (-1 for both when empty). A request passes through three steps from
// acceptance to a loaded response: one to update the indices and write a
// pushed value, one to read the new front and back entries from the ring
// memory, one to load the response register. A new request is accepted only
// once the previous one has loaded its response. A waiting response does not
// block the next request; the next response waits in its data stage until the
// response register is free. The ring memory needs no clearing after reset:
// only written entries are read.
`include "assert_macros.svh"

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_req_if.sink    i_req,
    deq_rsp_if.source  o_rsp
);

    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_status, n_status;

    logic             r_out_valid, n_out_valid;
    t_status          r_out_status;
    logic [CNT_W-1:0] r_out_count;
    t_data            r_out_front;
    t_data            r_out_back;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             out_load;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail_slot;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] back_slot;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    logic [DATA_W-1:0] mem_rdata_f;
    logic [DATA_W-1:0] mem_rdata_b;

    // handshake, no request taken while in reset
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_load    = (r_state == S_DATA) && (!r_out_valid || o_rsp.ready);

    // ring index arithmetic
    assign is_full   = (r_count == CNT_FULL);
    assign is_empty  = (r_count == '0);
    assign front_dec = (r_front == '0) ? IDX_LAST : r_front - 1'b1;
    assign front_inc = (r_front == IDX_LAST) ? '0 : r_front + 1'b1;
    assign tail_sum  = SUM_W'(r_front) + SUM_W'(r_count);
    assign tail_slot = IDX_W'((tail_sum >= SUM_CAP) ? tail_sum - SUM_CAP : tail_sum);
    assign back_sum  = tail_sum - 1'b1;
    assign back_slot = IDX_W'((back_sum >= SUM_CAP) ? back_sum - SUM_CAP : back_sum);

    // request decode and index update
    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = tail_slot;
        if (accept) begin
            n_status = ST_OK;
            case (i_req.req_type)
                REQ_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = front_dec;
                        n_front   = front_dec;
                        n_count   = r_count + 1'b1;
                    end
                end
                REQ_POP_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                REQ_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_front = front_inc;
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer and response register control
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        mem_re      = 1'b0;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_DATA;
            end
            S_DATA: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_front  <= is_empty ? EMPTY_READ : t_data'(mem_rdata_f);
            r_out_back   <= is_empty ? EMPTY_READ : t_data'(mem_rdata_b);
        end
    end

    // ring memory
    deq_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (i_req.push_value),
        .i_re      (mem_re),
        .i_raddr_a (r_front),
        .i_raddr_b (back_slot),
        .o_rdata_a (mem_rdata_f),
        .o_rdata_b (mem_rdata_b)
    );

    // response outputs
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.element_count = r_out_count;
    assign o_rsp.front_value   = r_out_front;
    assign o_rsp.back_value    = r_out_back;

    // checks
    `AST_ALWAYS(a_count_bound, r_count <= CNT_FULL, "element count above capacity")
    `AST_NEXT(a_accept_read, accept, r_state == S_READ, "accepted request not read next")
    `AST_SAME(a_load_from_data, $rose(r_out_valid), $past(r_state) == S_DATA,
              "response loaded outside data stage")
    `AST_NEXT(a_count_step, accept,
              (r_count == $past(r_count)) || (r_count == CNT_W'($past(r_count) + 1'b1)) ||
              (r_count == CNT_W'($past(r_count) - 1'b1)),
              "count moved by more than one")

endmodule

>>> bench/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded double-ended queue
// ----------------------------------------------------------------------------
// A table of directed requests covers the empty and full corners, the extreme
// values and the unused request codes. Random fill, drain and mixed request
// sequences follow. Each accepted request is applied to a behavioral ring
// kept in the bench, and every response is compared with the oldest
// predicted one. Both channels idle in random bursts, and at one point the
// response side holds off long enough for the queue to stall its input.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int    DEPTH        = 64;
    localparam int    TOTAL_ITEMS  = 1150;
    localparam int    CALM_TAIL    = 150;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    MAX_REPORTS  = 10;
    localparam t_data DATA_MAX     = 32'sh7FFF_FFFF;
    localparam t_data DATA_MIN     = 32'sh8000_0000;

    typedef struct packed {
        t_status    status;
        logic [6:0] count;
        t_data      front;
        t_data      back;
    } t_deq_resp;

    typedef struct {
        t_req      req;
        t_data     value;
        int        reps;
        bit        rnd_value;
        bit        typed;
        t_deq_resp want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_req_if             req_ch ();
    deq_rsp_if #(.CNT_W(7)) rsp_ch ();

    double_ended_queue #(
        .CAPACITY(DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // behavioral copy of the ring
    t_data      ring_model [DEPTH];
    logic [5:0] model_head;
    logic [6:0] model_count;

    t_deq_resp     expected_responses [$];
    t_directed_row directed_rows [$];

    bit sender_idle_on;
    bit receiver_idle_on;
    bit hold_off_pending;

    int issued;
    int n_responses;
    int n_mismatch;
    int n_full_rejects;
    int n_empty_rejects;
    int peak_count;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one request to the ring model, return the response it yields
    function automatic t_deq_resp apply_request(t_req r, t_data v);
        t_deq_resp  res;
        logic [5:0] slot;
        res.status = ST_OK;
        case (r)
            REQ_PUSH_BACK: begin
                if (model_count == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = model_head + model_count[5:0];
                    ring_model[slot] = v;
                    model_count++;
                end
            end
            REQ_PUSH_FRONT: begin
                if (model_count == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    model_head = model_head - 6'd1;
                    ring_model[model_head] = v;
                    model_count++;
                end
            end
            REQ_POP_BACK: begin
                if (model_count == 0) res.status = ST_EMPTY;
                else model_count--;
            end
            REQ_POP_FRONT: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    model_head = model_head + 6'd1;
                    model_count--;
                end
            end
            default: ;
        endcase
        res.count = model_count;
        if (model_count == 0) begin
            res.front = EMPTY_READ;
            res.back  = EMPTY_READ;
        end else begin
            slot      = model_head + model_count[5:0] - 6'd1;
            res.front = ring_model[model_head];
            res.back  = ring_model[slot];
        end
        return res;
    endfunction

    // push values lean toward the extremes and the empty read value
    function automatic t_data pick_value();
        case ($urandom_range(0, 7))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return EMPTY_READ;
            default: return t_data'($urandom);
        endcase
    endfunction

    // offer one request, wait for it to be taken, record what it should return
    task automatic issue_request(input t_req r, input t_data v, input bit typed,
                                 input t_deq_resp want);
        t_deq_resp predicted;
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r;
        req_ch.push_value <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = apply_request(r, v);
        expected_responses.push_back(typed ? want : predicted);
        issued++;
        if (predicted.status == ST_FULL) n_full_rejects++;
        if (predicted.status == ST_EMPTY) n_empty_rejects++;
        if (int'(predicted.count) > peak_count) peak_count = int'(predicted.count);
    endtask

    task automatic add_row(input t_req r, input t_data v, input int reps, input bit rnd,
                           input bit typed, input t_deq_resp want);
        t_directed_row row;
        row.req       = r;
        row.value     = v;
        row.reps      = reps;
        row.rnd_value = rnd;
        row.typed     = typed;
        row.want      = want;
        directed_rows.push_back(row);
    endtask

    // response side: ready with random stall bursts and one long hold-off
    initial begin
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_deq_resp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_responses++;
            if (expected_responses.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("[%0t] unexpected response: status %0d count %0d", $realtime,
                             rsp_ch.status, rsp_ch.element_count);
            end else begin
                want = expected_responses.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.element_count !== want.count ||
                    rsp_ch.front_value !== want.front || rsp_ch.back_value !== want.back) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("[%0t] resp %0d: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $realtime, n_responses, want.status, want.count,
                                 want.front, want.back, rsp_ch.status,
                                 rsp_ch.element_count, rsp_ch.front_value,
                                 rsp_ch.back_value);
                end
            end
        end
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("double_ended_queue_tb: FAIL");
        $finish;
    end

    // stimulus
    initial begin
        int        seq;
        int        target;
        int        n;
        bit        hold_done;
        t_req      r;

        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_QUERY;
        req_ch.push_value <= '0;
        i_rst_n           <= 1'b0;
        model_head        = '0;
        model_count       = '0;
        sender_idle_on    = 1'b1;
        receiver_idle_on  = 1'b1;
        hold_off_pending  = 1'b0;
        hold_done         = 1'b0;
        issued            = 0;
        n_responses       = 0;
        n_mismatch        = 0;
        n_full_rejects    = 0;
        n_empty_rejects   = 0;
        peak_count        = 0;

        // empty corners, extremes, unused codes, then fill past full and drain
        add_row(REQ_QUERY,      '0,       1, 0, 1, '{ST_OK,    7'd0, EMPTY_READ, EMPTY_READ});
        add_row(REQ_POP_BACK,   DATA_MAX, 1, 0, 1, '{ST_EMPTY, 7'd0, EMPTY_READ, EMPTY_READ});
        add_row(REQ_POP_FRONT,  DATA_MIN, 1, 0, 1, '{ST_EMPTY, 7'd0, EMPTY_READ, EMPTY_READ});
        add_row(REQ_PUSH_BACK,  DATA_MAX, 1, 0, 1, '{ST_OK,    7'd1, DATA_MAX, DATA_MAX});
        add_row(REQ_PUSH_FRONT, DATA_MIN, 1, 0, 1, '{ST_OK,    7'd2, DATA_MIN, DATA_MAX});
        add_row(REQ_QUERY,      '0,       1, 0, 1, '{ST_OK,    7'd2, DATA_MIN, DATA_MAX});
        add_row(t_req'(5),      DATA_MAX, 1, 0, 1, '{ST_OK,    7'd2, DATA_MIN, DATA_MAX});
        add_row(t_req'(6),      '0,       1, 0, 0, '0);
        add_row(t_req'(7),      EMPTY_READ, 1, 0, 0, '0);
        add_row(REQ_PUSH_BACK,  '0,       1, 0, 1, '{ST_OK,    7'd3, DATA_MIN, 32'sd0});
        add_row(REQ_PUSH_FRONT, EMPTY_READ, 1, 0, 1, '{ST_OK,  7'd4, EMPTY_READ, 32'sd0});
        add_row(REQ_POP_FRONT,  '0,       1, 0, 1, '{ST_OK,    7'd3, DATA_MIN, 32'sd0});
        add_row(REQ_POP_BACK,   '0,       1, 0, 1, '{ST_OK,    7'd2, DATA_MIN, DATA_MAX});
        add_row(REQ_POP_BACK,   '0,       1, 0, 1, '{ST_OK,    7'd1, DATA_MIN, DATA_MIN});
        add_row(REQ_POP_FRONT,  '0,       1, 0, 1, '{ST_OK,    7'd0, EMPTY_READ, EMPTY_READ});
        add_row(REQ_PUSH_FRONT, 32'sh5555_5555, 1, 0, 0, '0);
        add_row(REQ_POP_BACK,   '0,       1, 0, 0, '0);
        add_row(REQ_PUSH_BACK,  '0,   DEPTH, 1, 0, '0);
        add_row(REQ_PUSH_BACK,  32'shAAAA_AAAA, 1, 0, 0, '0);
        add_row(REQ_PUSH_FRONT, DATA_MAX, 1, 0, 0, '0);
        add_row(REQ_QUERY,      '0,       1, 0, 0, '0);
        add_row(REQ_POP_FRONT,  '0,   DEPTH, 0, 0, '0);
        add_row(REQ_POP_FRONT,  '0,       1, 0, 1, '{ST_EMPTY, 7'd0, EMPTY_READ, EMPTY_READ});

        // synchronous reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++)
                issue_request(directed_rows[i].req,
                              directed_rows[i].rnd_value ? pick_value() : directed_rows[i].value,
                              directed_rows[i].typed, directed_rows[i].want);
        end

        // random fill, drain and mixed sequences
        while (issued < TOTAL_ITEMS) begin
            if (TOTAL_ITEMS - issued < CALM_TAIL) begin
                sender_idle_on   = 1'b0;
                receiver_idle_on = 1'b0;
            end else begin
                n = $urandom_range(0, 3);
                sender_idle_on   = n[0];
                receiver_idle_on = n[1];
            end
            seq = $urandom_range(0, 9);
            if (seq < 4) begin
                // fill, to capacity and past it half the time
                if (!hold_done && issued > 300) begin
                    hold_off_pending = 1'b1;
                    hold_done        = 1'b1;
                end
                target = $urandom_range(0, 1) ? DEPTH : $urandom_range(1, DEPTH - 1);
                while (model_count < target)
                    issue_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                  pick_value(), 1'b0, '0);
                if (target == DEPTH) begin
                    repeat ($urandom_range(1, 3))
                        issue_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                      pick_value(), 1'b0, '0);
                end
            end else if (seq < 7) begin
                // drain, to empty and past it half the time
                target = $urandom_range(0, 1) ? 0 : $urandom_range(0, model_count);
                while (model_count > target)
                    issue_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
                                  pick_value(), 1'b0, '0);
                if (target == 0) begin
                    repeat ($urandom_range(1, 3))
                        issue_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
                                      pick_value(), 1'b0, '0);
                end
            end else begin
                // any request code, unused ones included
                repeat ($urandom_range(8, 40)) begin
                    r = t_req'($urandom_range(0, 7));
                    issue_request(r, pick_value(), 1'b0, '0);
                end
            end
        end
        req_ch.valid <= 1'b0;

        // drain outstanding responses, then a few quiet cycles
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d requests, %0d responses, peak occupancy %0d",
                 issued, n_responses, peak_count);
        $display("rejected pushes on full %0d, pops on empty %0d, mismatches %0d",
                 n_full_rejects, n_empty_rejects, n_mismatch);
        if (n_mismatch == 0 && expected_responses.size() == 0) begin
            $display("double_ended_queue_tb: PASS");
        end else begin
            $display("double_ended_queue_tb: FAIL");
        end
        $finish;
    end

endmodule
